FILE: hw/rtl/tsl_pkg.sv
// Shared types, constants and constant tables for the twin-sine pixel colour core.
`timescale 1ns / 1ps

package tsl_pkg;

  // Field widths of the transfers.
  localparam int unsigned FRAME_W = 16;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned PHASE_W = 8;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned SAMPLE_W = 16;

  // Geometry of the cylinder.
  localparam int unsigned PIXELS_AROUND = 25;
  localparam int unsigned COL_W = $clog2(PIXELS_AROUND);
  localparam int unsigned ROW_W = $clog2(((2 ** INDEX_W) - 1) / PIXELS_AROUND + 1);

  // Column and row split: reciprocal multiply followed by one correction step.
  localparam int unsigned COL_SHIFT = INDEX_W;
  localparam int unsigned COL_PROD_W = 2 * INDEX_W;
  localparam logic [INDEX_W-1:0] COL_RECIP = INDEX_W'((2 ** COL_SHIFT) / PIXELS_AROUND);

  // Small wave: phase = (2y - f) * 32 / 3, truncated toward zero.
  localparam int unsigned T_W = FRAME_W + 2;
  localparam int unsigned SMALL_PRE_SHIFT = 5;
  localparam int unsigned NUM_W = 21;
  localparam int unsigned RECIP_W = 22;
  localparam int unsigned SMALL_SHIFT = 23;
  localparam logic [RECIP_W-1:0] SMALL_RECIP =
    RECIP_W'(((64'd1 << SMALL_SHIFT) + 64'd2) / 64'd3);

  // Large wave: phase = (18f + 20y) / 5.
  localparam int unsigned LARGE_SHIFT = 24;
  localparam logic [RECIP_W-1:0] LARGE_RECIP =
    RECIP_W'(((64'd1 << LARGE_SHIFT) + 64'd4) / 64'd5);
  localparam int unsigned PROD_W = NUM_W + RECIP_W;

  // Brightness mix and colour scaling.
  localparam int unsigned MIX_W = 24;
  localparam int unsigned SUM_W = 25;
  localparam int unsigned DIFF_W = 23;
  localparam logic [SUM_W-1:0] STRIPE_UNITS = SUM_W'(80 * 32768);
  localparam int unsigned WEIGHT_W = 28;
  localparam int unsigned SCALED_W = WEIGHT_W + CHAN_W;
  localparam int unsigned SCALED_SHIFT = 15;
  localparam int unsigned QUOT_IN_W = SCALED_W - SCALED_SHIFT;
  localparam int unsigned COLOR_SHIFT = 31;
  localparam logic [RECIP_W-1:0] COLOR_RECIP =
    RECIP_W'(((64'd1 << COLOR_SHIFT) + 64'd999) / 64'd1000);
  localparam int unsigned COLOR_PROD_W = QUOT_IN_W + RECIP_W;
  localparam int unsigned LEVEL_W = COLOR_PROD_W - COLOR_SHIFT;

  // Decoupling queue.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Transfer payloads.
  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [INDEX_W-1:0] pixel_index;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] pixel_number;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
  } out_item_t;

  // Classified item held in the queue between front and back.
  typedef struct packed {
    logic [INDEX_W-1:0] pixel_index;
    logic [PHASE_W-1:0] alt_phase;
    logic [PHASE_W-1:0] small_phase;
    logic [PHASE_W-1:0] large_phase;
  } phase_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef logic [(2 ** PHASE_W)-1:0][SAMPLE_W-1:0] sine_table_t;
  typedef logic [(2 ** COL_W)-1:0][PHASE_W-1:0] alt_table_t;

  // First-quadrant sine in Q30 by Taylor series, rounded to Q1.15.
  function automatic logic [SAMPLE_W-1:0] quarter_sine_f(input int unsigned k);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] q;
    longint sum;
    x = (64'(k) * 64'd6746513154) >> 8;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = (64'(sum) + (64'd1 << 14)) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[SAMPLE_W-1:0];
  endfunction

  // Full sine table, mirrored from the first quadrant.
  function automatic sine_table_t sine_table_f();
    sine_table_t tbl;
    int unsigned m;
    logic [SAMPLE_W-1:0] v;
    for (int unsigned k = 0; k < 2 ** PHASE_W; k++) begin
      m = k & 127;
      v = (m <= 64) ? quarter_sine_f(m) : quarter_sine_f(128 - m);
      tbl[k] = (k < 128) ? v : SAMPLE_W'(-v);
    end
    return tbl;
  endfunction

  // Altitude phase per column, including the quarter-turn offset.
  function automatic alt_table_t alt_table_f();
    alt_table_t tbl;
    for (int unsigned k = 0; k < 2 ** COL_W; k++) begin
      tbl[k] = PHASE_W'(((k * 256) / (PIXELS_AROUND - 1) + 64) & 255);
    end
    return tbl;
  endfunction

  localparam sine_table_t SINE_ROM = sine_table_f();
  localparam alt_table_t ALT_TABLE = alt_table_f();

endpackage

FILE: hw/rtl/twin_sine_led_pattern_pixel_core.sv
// Top level of the twin-sine pixel colour core: configuration register and the three parts.
`timescale 1ns / 1ps

// Takes one frame number and pixel index per transfer and returns that pixel's colour,
// one result per input, in order. Sustained rate is one pixel per clock while the output
// is not stalled: every stage of the four-stage front and the eight-stage back takes a new
// item each cycle, and the four-entry queue between them lets either side stall without
// stopping the other. An item passes the four front stages, the queue and the eight back
// stages in turn. Widest logic per stage is a reciprocal multiply of up to 21 by 22
// bits. The max_brightness register (reset 255) is written through the configuration
// channel, which is always ready; write it only while no pixel is in flight.
module twin_sine_led_pattern_pixel_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tsl_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tsl_pkg::out_item_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tsl_pkg::CHAN_W-1:0]  cfg_data_i
);

  logic [tsl_pkg::CHAN_W-1:0] max_brightness_q;
  logic                       push;
  logic                       pop;
  tsl_pkg::phase_item_t       push_data;
  tsl_pkg::phase_item_t       pop_data;
  tsl_pkg::queue_status_t     q_status;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_brightness_q <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_brightness_q <= cfg_data_i;
    end
  end

  tsl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  tsl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  tsl_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_status_i       (q_status),
    .pop_o            (pop),
    .pop_data_i       (pop_data),
    .max_brightness_i (max_brightness_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_o       (out_data_o)
  );

endmodule

FILE: hw/rtl/tsl_front.sv
// Front pipeline: accepts pixel transfers, splits the index and forms the three phases.
`timescale 1ns / 1ps

module tsl_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tsl_pkg::in_item_t     in_data_i,
  input  tsl_pkg::queue_status_t q_status_i,
  output logic                  push_o,
  output tsl_pkg::phase_item_t  push_data_o
);

  localparam int unsigned STAGES = 4;

  logic [STAGES-1:0] valid_q;
  logic              advance;

  // Stage 1 registers.
  logic [tsl_pkg::FRAME_W-1:0]    s1_f_q;
  logic [tsl_pkg::INDEX_W-1:0]    s1_idx_q;
  logic [tsl_pkg::COL_PROD_W-1:0] s1_prod_q;

  // Stage 2 registers.
  logic [tsl_pkg::FRAME_W-1:0] s2_f_q;
  logic [tsl_pkg::INDEX_W-1:0] s2_idx_q;
  logic [tsl_pkg::COL_W-1:0]   s2_x_q;
  logic [tsl_pkg::ROW_W-1:0]   s2_y_q;

  // Stage 3 registers.
  logic [tsl_pkg::INDEX_W-1:0] s3_idx_q;
  logic [tsl_pkg::PHASE_W-1:0] s3_pa_q;
  logic                        s3_neg_q;
  logic [tsl_pkg::NUM_W-1:0]   s3_m_q;
  logic [tsl_pkg::NUM_W-1:0]   s3_n_q;

  // Stage 4 registers.
  logic [tsl_pkg::INDEX_W-1:0] s4_idx_q;
  logic [tsl_pkg::PHASE_W-1:0] s4_pa_q;
  logic                        s4_neg_q;
  logic [tsl_pkg::PHASE_W-1:0] s4_qs_q;
  logic [tsl_pkg::PHASE_W-1:0] s4_ql_q;

  // Combinational values between stages.
  logic [tsl_pkg::ROW_W-1:0]   q0;
  logic [tsl_pkg::INDEX_W-1:0] qp;
  logic [tsl_pkg::INDEX_W-1:0] r0;
  logic [tsl_pkg::COL_W-1:0]   x_d;
  logic [tsl_pkg::ROW_W-1:0]   y_d;
  logic [tsl_pkg::COL_W-1:0]   xr;
  logic signed [tsl_pkg::T_W-1:0] t;
  logic [tsl_pkg::FRAME_W-1:0] mag;
  logic [tsl_pkg::PROD_W-1:0]  small_prod;
  logic [tsl_pkg::PROD_W-1:0]  large_prod;

  // The whole pipeline moves unless a finished item waits on a full queue.
  assign advance    = !(valid_q[STAGES-1] && q_status_i.full);
  assign in_stall_o = !advance;
  assign push_o     = valid_q[STAGES-1] && !q_status_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[STAGES-2:0], in_valid_i};
    end
  end

  // Column and row split with one correction step on the reciprocal estimate.
  always_comb begin
    q0 = tsl_pkg::ROW_W'(s1_prod_q >> tsl_pkg::COL_SHIFT);
    qp = tsl_pkg::INDEX_W'(q0) * tsl_pkg::INDEX_W'(tsl_pkg::PIXELS_AROUND);
    r0 = s1_idx_q - qp;
    if (r0 >= tsl_pkg::INDEX_W'(tsl_pkg::PIXELS_AROUND)) begin
      y_d = q0 + 1'b1;
      x_d = tsl_pkg::COL_W'(r0 - tsl_pkg::INDEX_W'(tsl_pkg::PIXELS_AROUND));
    end else begin
      y_d = q0;
      x_d = tsl_pkg::COL_W'(r0);
    end
  end

  // Serpentine reversal and the operands of the two travelling waves.
  always_comb begin
    xr = s2_y_q[0] ? (tsl_pkg::COL_W'(tsl_pkg::PIXELS_AROUND - 1) - s2_x_q) : s2_x_q;
    t = $signed(tsl_pkg::T_W'({s2_y_q, 1'b0})) - $signed(tsl_pkg::T_W'(s2_f_q));
    mag = t[tsl_pkg::T_W-1] ? tsl_pkg::FRAME_W'(-t) : tsl_pkg::FRAME_W'(t);
  end

  // Reciprocal multiplies for the divisions by three and by five.
  assign small_prod = tsl_pkg::PROD_W'(s3_m_q) * tsl_pkg::PROD_W'(tsl_pkg::SMALL_RECIP);
  assign large_prod = tsl_pkg::PROD_W'(s3_n_q) * tsl_pkg::PROD_W'(tsl_pkg::LARGE_RECIP);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_f_q    <= in_data_i.frame_number;
      s1_idx_q  <= in_data_i.pixel_index;
      s1_prod_q <= tsl_pkg::COL_PROD_W'(in_data_i.pixel_index) *
                   tsl_pkg::COL_PROD_W'(tsl_pkg::COL_RECIP);

      s2_f_q   <= s1_f_q;
      s2_idx_q <= s1_idx_q;
      s2_x_q   <= x_d;
      s2_y_q   <= y_d;

      s3_idx_q <= s2_idx_q;
      s3_pa_q  <= tsl_pkg::ALT_TABLE[xr];
      s3_neg_q <= t[tsl_pkg::T_W-1];
      s3_m_q   <= tsl_pkg::NUM_W'({mag, tsl_pkg::SMALL_PRE_SHIFT'(0)});
      s3_n_q   <= tsl_pkg::NUM_W'(s2_f_q) * tsl_pkg::NUM_W'(18) +
                  tsl_pkg::NUM_W'(s2_y_q) * tsl_pkg::NUM_W'(20);

      s4_idx_q <= s3_idx_q;
      s4_pa_q  <= s3_pa_q;
      s4_neg_q <= s3_neg_q;
      s4_qs_q  <= small_prod[tsl_pkg::SMALL_SHIFT +: tsl_pkg::PHASE_W];
      s4_ql_q  <= large_prod[tsl_pkg::LARGE_SHIFT +: tsl_pkg::PHASE_W];
    end
  end

  // A negative small-wave quotient is negated, then kept to eight bits.
  always_comb begin
    push_data_o.pixel_index = s4_idx_q;
    push_data_o.alt_phase   = s4_pa_q;
    push_data_o.small_phase = s4_neg_q ? tsl_pkg::PHASE_W'(-s4_qs_q) : s4_qs_q;
    push_data_o.large_phase = s4_ql_q;
  end

endmodule

FILE: hw/rtl/tsl_queue.sv
// Short queue that decouples the phase front end from the colour back end.
`timescale 1ns / 1ps

module tsl_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  tsl_pkg::phase_item_t   push_data_i,
  input  logic                   pop_i,
  output tsl_pkg::phase_item_t   pop_data_o,
  output tsl_pkg::queue_status_t status_o
);

  tsl_pkg::phase_item_t entry_q [tsl_pkg::QUEUE_DEPTH];
  logic [tsl_pkg::QPTR_W-1:0] wptr_q;
  logic [tsl_pkg::QPTR_W-1:0] rptr_q;
  logic [tsl_pkg::QCNT_W-1:0] count_q;
  logic [tsl_pkg::QCNT_W-1:0] count_d;

  assign status_o.full  = (count_q == tsl_pkg::QCNT_W'(tsl_pkg::QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = entry_q[rptr_q];

  // Occupancy follows the push and pop strobes.
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wptr_q <= (wptr_q == tsl_pkg::QPTR_W'(tsl_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == tsl_pkg::QPTR_W'(tsl_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

  // The front never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !status_o.full)
    else $error("queue pushed while full");

  // The back never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !status_o.empty)
    else $error("queue popped while empty");

  // A lone push grows the occupancy by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == tsl_pkg::QCNT_W'($past(count_q) + 1'b1)))
    else $error("queue occupancy lost a push");

endmodule

FILE: hw/rtl/tsl_back.sv
// Back pipeline: sine lookups, brightness mix and clamped colour channels.
`timescale 1ns / 1ps

module tsl_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tsl_pkg::queue_status_t q_status_i,
  output logic                   pop_o,
  input  tsl_pkg::phase_item_t   pop_data_i,
  input  logic [tsl_pkg::CHAN_W-1:0] max_brightness_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output tsl_pkg::out_item_t     out_data_o
);

  localparam int unsigned STAGES = 8;
  localparam int unsigned LANES = 3;
  localparam int unsigned RED = 0;
  localparam int unsigned GREEN = 1;
  localparam int unsigned BLUE = 2;

  logic [STAGES-1:0] valid_q;
  logic              advance;

  // Pixel number travels alongside the first seven stages.
  logic [STAGES-2:0][tsl_pkg::INDEX_W-1:0] idx_q;

  logic signed [tsl_pkg::SAMPLE_W-1:0] c_q, s_q, l_q;
  logic signed [tsl_pkg::MIX_W-1:0]    pc_q, ps_q, pl_q;
  logic signed [tsl_pkg::SUM_W-1:0]    bsum_q;
  logic                                pos_q;
  logic [tsl_pkg::DIFF_W-1:0]          d_q;
  logic [LANES-1:0][tsl_pkg::WEIGHT_W-1:0] dw_q;
  logic [LANES-1:0][tsl_pkg::SCALED_W-1:0] x_q;
  logic [LANES-1:0][tsl_pkg::LEVEL_W-1:0]  lvl_q;
  tsl_pkg::out_item_t                  out_q;

  logic                                pos_d;
  logic [tsl_pkg::MIX_W-1:0]           mag;
  logic signed [tsl_pkg::SUM_W-1:0]    diff;
  logic [tsl_pkg::DIFF_W-1:0]          d_d;
  logic [tsl_pkg::WEIGHT_W-1:0]        d_low, d_mid, d_high;
  logic [LANES-1:0][tsl_pkg::WEIGHT_W-1:0] dw_d;
  logic [LANES-1:0][tsl_pkg::LEVEL_W-1:0]  lvl_d;
  logic [LANES-1:0][tsl_pkg::CHAN_W-1:0]   chan_d;
  logic [tsl_pkg::COLOR_PROD_W-1:0]    cprod;

  // The pipeline moves unless a result sits unclaimed at the output.
  assign advance     = !(valid_q[STAGES-1] && out_stall_i);
  assign pop_o       = advance && !q_status_i.empty;
  assign out_valid_o = valid_q[STAGES-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[STAGES-2:0], pop_o};
    end
  end

  // Sign split and stripe offset; a non-positive distance gives black.
  always_comb begin
    pos_d = !bsum_q[tsl_pkg::SUM_W-1] && (bsum_q != '0);
    mag   = bsum_q[tsl_pkg::SUM_W-1] ? tsl_pkg::MIX_W'(-bsum_q) : tsl_pkg::MIX_W'(bsum_q);
    diff  = $signed({1'b0, mag}) - $signed(tsl_pkg::STRIPE_UNITS);
    d_d   = diff[tsl_pkg::SUM_W-1] ? '0 : diff[tsl_pkg::DIFF_W-1:0];
  end

  // Weights: blue-heavy on the positive side, red-heavy on the negative side.
  always_comb begin
    d_low       = tsl_pkg::WEIGHT_W'(d_q);
    d_mid       = tsl_pkg::WEIGHT_W'(d_q) * tsl_pkg::WEIGHT_W'(5);
    d_high      = tsl_pkg::WEIGHT_W'(d_q) * tsl_pkg::WEIGHT_W'(20);
    dw_d[RED]   = pos_q ? d_low : d_high;
    dw_d[GREEN] = d_mid;
    dw_d[BLUE]  = pos_q ? d_high : d_low;
  end

  // Division by 1000 through a reciprocal, then the clamp to the maximum.
  always_comb begin
    cprod = '0;
    for (int i = 0; i < LANES; i++) begin
      cprod = tsl_pkg::COLOR_PROD_W'(x_q[i][tsl_pkg::SCALED_W-1:tsl_pkg::SCALED_SHIFT]) *
              tsl_pkg::COLOR_PROD_W'(tsl_pkg::COLOR_RECIP);
      lvl_d[i] = cprod[tsl_pkg::COLOR_PROD_W-1:tsl_pkg::COLOR_SHIFT];
      chan_d[i] = (lvl_q[i] > tsl_pkg::LEVEL_W'(max_brightness_i)) ?
                  max_brightness_i : lvl_q[i][tsl_pkg::CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      idx_q <= {idx_q[STAGES-3:0], pop_data_i.pixel_index};

      c_q <= $signed(tsl_pkg::SINE_ROM[pop_data_i.alt_phase]);
      s_q <= $signed(tsl_pkg::SINE_ROM[pop_data_i.small_phase]);
      l_q <= $signed(tsl_pkg::SINE_ROM[pop_data_i.large_phase]);

      pc_q <= tsl_pkg::MIX_W'(c_q) * $signed(tsl_pkg::MIX_W'(100));
      ps_q <= tsl_pkg::MIX_W'(s_q) * $signed(tsl_pkg::MIX_W'(70));
      pl_q <= tsl_pkg::MIX_W'(l_q) * $signed(tsl_pkg::MIX_W'(98));

      bsum_q <= tsl_pkg::SUM_W'(pc_q) - tsl_pkg::SUM_W'(ps_q) - tsl_pkg::SUM_W'(pl_q);

      pos_q <= pos_d;
      d_q   <= d_d;

      dw_q <= dw_d;

      for (int i = 0; i < LANES; i++) begin
        x_q[i] <= tsl_pkg::SCALED_W'(dw_q[i]) * tsl_pkg::SCALED_W'(max_brightness_i);
      end

      lvl_q <= lvl_d;

      out_q.pixel_number <= idx_q[STAGES-2];
      out_q.red          <= chan_d[RED];
      out_q.green        <= chan_d[GREEN];
      out_q.blue         <= chan_d[BLUE];
    end
  end

endmodule
